FILE: design/gfalu_pkg.sv
package gfalu_pkg;

    // Field and port widths
    localparam int ELEM_W  = 4;
    localparam int LOG_W   = 4;
    localparam int EXP_W   = 5;
    localparam int DEG_W   = 3;
    localparam int POLY_W  = 5;
    localparam int CIDX_W  = 4;
    localparam int CDATA_W = 3;

    localparam int MAX_DEGREE_DEF = 4;

    // Request codes
    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_MUL = 2'd1;
    localparam logic [1:0] REQ_LOG = 2'd2;
    localparam logic [1:0] REQ_EXP = 2'd3;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FIELD_DEGREE = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_POLY_CHOICE  = 4'd1;

    // Primitive polynomials: x^2+x+1, x^3+x+1, x^3+x^2+1, x^4+x+1, x^4+x^3+1
    localparam logic [POLY_W-1:0] POLY_N2  = 5'd7;
    localparam logic [POLY_W-1:0] POLY_N3A = 5'd11;
    localparam logic [POLY_W-1:0] POLY_N3B = 5'd13;
    localparam logic [POLY_W-1:0] POLY_N4A = 5'd19;
    localparam logic [POLY_W-1:0] POLY_N4B = 5'd25;

    // One table write from the builder: antilog[idx] = elem, log[elem] = log_val
    typedef struct packed {
        logic              we;
        logic [LOG_W-1:0]  idx;
        logic [ELEM_W-1:0] elem;
        logic [LOG_W-1:0]  log_val;
    } gfalu_wr_t;

    // Degree actually in force; anything unsupported falls back to n=2
    function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] deg,
                                                    input int max_deg);
        logic ok;
        ok = (deg >= 3'd2) && (deg <= 3'd4) && (int'(deg) <= max_deg);
        return ok ? deg : 3'd2;
    endfunction

    function automatic logic [POLY_W-1:0] poly_for(input logic [DEG_W-1:0] n,
                                                   input logic choice);
        logic [POLY_W-1:0] p;
        case (n)
            3'd3:    p = choice ? POLY_N3B : POLY_N3A;
            3'd4:    p = choice ? POLY_N4B : POLY_N4A;
            default: p = POLY_N2;
        endcase
        return p;
    endfunction

    // 2^n - 1
    function automatic logic [ELEM_W-1:0] mask_for(input logic [DEG_W-1:0] n);
        logic [ELEM_W-1:0] m;
        case (n)
            3'd3:    m = 4'd7;
            3'd4:    m = 4'd15;
            default: m = 4'd3;
        endcase
        return m;
    endfunction

endpackage

FILE: design/gf2n_small_field_alu.sv
// Channel   Dir  Fields (low bit first)
// s_        in   tdata: operand_a[3:0] operand_b[7:4] exponent[12:8]; tuser: req_type[1:0]
// m_        out  tdata: value_out[3:0] log_out[8:4]; tuser: status[0]
// cfg_      in   cfg_index: register index, cfg_data: write data (always ready)
//
// One request per cycle while s_tready is high; each result goes through the log read at the
// taking edge, then the antilog read, then the output register before it is offered on m_.
// After reset and after every register write the tables are rebuilt: start_reg is raised,
// then the builder writes all 2^n-1 entries; during both, s_tready stays low.
// A stalled m_ side holds the whole pipeline, memory read registers included.
module gf2n_small_field_alu #(
    parameter int MAX_DEGREE = gfalu_pkg::MAX_DEGREE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // operand_a, operand_b, exponent
    input  logic [1:0]                        s_tuser,   // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // value_out, log_out
    output logic [0:0]                        m_tuser,   // status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gfalu_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [gfalu_pkg::CDATA_W-1:0]     cfg_data
);

    localparam int AW = MAX_DEGREE;

    // Configuration registers
    logic [gfalu_pkg::DEG_W-1:0] degree_reg;
    logic                        choice_reg;
    logic                        start_reg;
    logic                        cfg_hit;
    logic [gfalu_pkg::DEG_W-1:0] n_eff;
    logic [gfalu_pkg::ELEM_W-1:0] mask;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       (cfg_index == gfalu_pkg::CFG_FIELD_DEGREE ||
                        cfg_index == gfalu_pkg::CFG_POLY_CHOICE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= 3'd2;
            choice_reg <= 1'b0;
            start_reg  <= 1'b1;
        end else begin
            start_reg <= cfg_hit;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == gfalu_pkg::CFG_FIELD_DEGREE)
                    degree_reg <= cfg_data;
                else if (cfg_index == gfalu_pkg::CFG_POLY_CHOICE)
                    choice_reg <= cfg_data[0];
            end
        end
    end

    assign n_eff = gfalu_pkg::eff_degree(degree_reg, MAX_DEGREE);
    assign mask  = gfalu_pkg::mask_for(n_eff);

    // Table builder
    logic                 build_busy;
    gfalu_pkg::gfalu_wr_t wr;

    gfalu_builder u_builder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .degree  (n_eff),
        .choice  (choice_reg),
        .busy    (build_busy),
        .wr      (wr)
    );

    // Pipeline control: everything moves together
    logic adv, s_take;
    logic m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv && !start_reg && !build_busy;
    assign s_take   = s_tvalid && s_tready;

    logic [gfalu_pkg::ELEM_W-1:0] in_a, in_b;
    assign in_a = s_tdata[3:0] & mask;
    assign in_b = s_tdata[7:4] & mask;

    // Stage 1: request fields, log reads in flight
    logic                         s1_valid_reg;
    logic [1:0]                   s1_req_reg;
    logic [gfalu_pkg::ELEM_W-1:0] s1_a_reg, s1_b_reg;
    logic [gfalu_pkg::EXP_W-1:0]  s1_e_reg;
    logic [gfalu_pkg::LOG_W-1:0]  log_a, log_b;
    logic [gfalu_pkg::ELEM_W-1:0] alog_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_take;
        end
        if (adv) begin
            s1_req_reg <= s_tuser;
            s1_a_reg   <= in_a;
            s1_b_reg   <= in_b;
            s1_e_reg   <= s_tdata[12:8];
        end
    end

    // Sum of logs modulo 2^n-1, exponent range check, antilog address
    logic [gfalu_pkg::EXP_W-1:0]  sum_raw;
    logic [gfalu_pkg::LOG_W-1:0]  sum_mod;
    logic                         e_neg, e_bad;
    logic [gfalu_pkg::ELEM_W-1:0] alog_idx;

    always_comb begin
        sum_raw = {1'b0, log_a} + {1'b0, log_b};
        if (sum_raw >= {1'b0, mask})
            sum_raw = sum_raw - {1'b0, mask};
        sum_mod = sum_raw[gfalu_pkg::LOG_W-1:0];
        e_neg   = (s1_e_reg == 5'h1F);
        e_bad   = !e_neg && !(!s1_e_reg[4] && (s1_e_reg[3:0] <= mask - 4'd1));
        if (s1_req_reg == gfalu_pkg::REQ_MUL)
            alog_idx = sum_mod + 4'd1;
        else
            alog_idx = s1_e_reg[3:0] + 4'd1;
    end

    gfalu_tables #(
        .ADDR_W (AW)
    ) u_tables (
        .aclk       (aclk),
        .wr         (wr),
        .rd_en      (adv),
        .log_addr_a (AW'(in_a)),
        .log_addr_b (AW'(in_b)),
        .alog_addr  (AW'(alog_idx)),
        .log_a      (log_a),
        .log_b      (log_b),
        .alog_data  (alog_data)
    );

    // Stage 2: antilog read in flight
    logic                         s2_valid_reg;
    logic [1:0]                   s2_req_reg;
    logic                         s2_zero_reg, s2_eneg_reg, s2_ebad_reg;
    logic [gfalu_pkg::EXP_W-1:0]  s2_log_reg;
    logic [gfalu_pkg::ELEM_W-1:0] s2_xor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv) begin
            s2_req_reg  <= s1_req_reg;
            s2_zero_reg <= (s1_a_reg == 4'd0) || (s1_b_reg == 4'd0);
            s2_eneg_reg <= e_neg;
            s2_ebad_reg <= e_bad;
            s2_log_reg  <= (s1_a_reg == 4'd0) ? 5'h1F : {1'b0, log_a};
            s2_xor_reg  <= s1_a_reg ^ s1_b_reg;
        end
    end

    // Result selection
    logic [gfalu_pkg::ELEM_W-1:0] value_sel;
    logic [gfalu_pkg::EXP_W-1:0]  log_sel;
    logic                         status_sel;

    always_comb begin
        value_sel  = 4'd0;
        log_sel    = 5'd0;
        status_sel = 1'b0;
        case (s2_req_reg)
            gfalu_pkg::REQ_ADD: value_sel = s2_xor_reg;
            gfalu_pkg::REQ_MUL: value_sel = s2_zero_reg ? 4'd0 : alog_data;
            gfalu_pkg::REQ_LOG: log_sel   = s2_log_reg;
            gfalu_pkg::REQ_EXP: begin
                value_sel  = (s2_eneg_reg || s2_ebad_reg) ? 4'd0 : alog_data;
                status_sel = s2_ebad_reg;
            end
            default: value_sel = 4'd0;
        endcase
    end

    // Output register
    logic [15:0] m_tdata_reg;
    logic        m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= s2_valid_reg;
        end
        if (adv) begin
            m_tdata_reg  <= {7'd0, log_sel, value_sel};
            m_status_reg <= status_sel;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_status_reg;

    // Checks
    a_no_take_in_build: assert property (@(posedge aclk) disable iff (!aresetn)
        build_busy |-> !s_take)
        else $error("request taken while tables are being rebuilt");

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> !s_tready)
        else $error("input not held off after a register write");

    a_status_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[8:0] == 9'd0))
        else $error("error status with non-zero result data");

endmodule

FILE: design/gfalu_builder.sv
module gfalu_builder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gfalu_pkg::DEG_W-1:0]   degree,
    input  logic                          choice,
    output logic                          busy,
    output gfalu_pkg::gfalu_wr_t          wr
);

    logic                               busy_reg, busy_next;
    logic [gfalu_pkg::LOG_W-1:0]        idx_reg, idx_next;
    logic [gfalu_pkg::ELEM_W-1:0]       v_reg, v_next;
    logic [gfalu_pkg::POLY_W-1:0]       poly;
    logic [gfalu_pkg::ELEM_W-1:0]       mask;
    logic [gfalu_pkg::POLY_W-1:0]       shifted;

    assign poly = gfalu_pkg::poly_for(degree, choice);
    assign mask = gfalu_pkg::mask_for(degree);

    // Next power of alpha: shift and reduce when bit n comes up
    always_comb begin
        shifted = {v_reg, 1'b0};
        if (shifted[degree])
            shifted = shifted ^ poly;
    end

    // Sweep over 1 .. 2^n-1, one table entry per cycle
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        v_next    = v_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = 4'd1;
            v_next    = 4'd1;
        end else if (busy_reg) begin
            if (idx_reg == mask) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 4'd1;
                v_next   = shifted[gfalu_pkg::ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        idx_reg <= idx_next;
        v_reg   <= v_next;
    end

    assign busy       = busy_reg;
    assign wr.we      = busy_reg;
    assign wr.idx     = idx_reg;
    assign wr.elem    = v_reg;
    assign wr.log_val = idx_reg - 4'd1;

endmodule

FILE: design/gfalu_tables.sv
module gfalu_tables #(
    parameter int ADDR_W = gfalu_pkg::MAX_DEGREE_DEF
) (
    input  logic                          aclk,
    input  gfalu_pkg::gfalu_wr_t          wr,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             log_addr_a,
    input  logic [ADDR_W-1:0]             log_addr_b,
    input  logic [ADDR_W-1:0]             alog_addr,
    output logic [gfalu_pkg::LOG_W-1:0]   log_a,
    output logic [gfalu_pkg::LOG_W-1:0]   log_b,
    output logic [gfalu_pkg::ELEM_W-1:0]  alog_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [gfalu_pkg::ELEM_W-1:0] alog_mem [DEPTH];
    logic [gfalu_pkg::LOG_W-1:0]  log_mem  [DEPTH];

    // Write port, driven by the builder sweep only
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            alog_mem[ADDR_W'(wr.idx)]  <= wr.elem;
            log_mem[ADDR_W'(wr.elem)]  <= wr.log_val;
        end
    end

    // Registered reads, held while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            log_a     <= log_mem[log_addr_a];
            log_b     <= log_mem[log_addr_b];
            alog_data <= alog_mem[alog_addr];
        end
    end

endmodule
